@@ sv/pvp_pkg.sv @@
// ----------------------------------------------------------------------------
// pvp_pkg
// Shared types and constants of the perspective vertex projection unit.
// ----------------------------------------------------------------------------
package pvp_pkg;

  localparam int SCREEN_W = 500;
  localparam int SCREEN_H = 500;

  localparam logic signed [12:0] HALF_W = 13'(SCREEN_W / 2);
  localparam logic signed [12:0] HALF_H = 13'(SCREEN_H / 2);

  localparam int COORD_W = 16;
  localparam int ROW_W   = 48;
  localparam int FOCAL_W = 12;
  localparam int CIDX_W  = 3;
  localparam int DIFF_W  = 17;
  localparam int PROD_W  = 33;
  localparam int DOT_W   = 35;
  localparam int NUM_W   = 48;
  localparam int QUO_W   = 16;
  localparam int TRIAL_W = DOT_W + QUO_W;

  localparam logic [ROW_W-1:0]   ROT0_RST  = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0]   ROT1_RST  = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0]   ROT2_RST  = 48'h4000_0000_0000;
  localparam logic [COORD_W-1:0] CAMZ_RST  = 16'hCFFC;
  localparam logic [FOCAL_W-1:0] FOCAL_RST = 12'd250;

  localparam logic [COORD_W-1:0] SAT_POS = 16'h7FFF;
  localparam logic [COORD_W-1:0] SAT_NEG = 16'h8000;

  typedef enum logic [CIDX_W-1:0] {
    REG_ROT_ROW0 = 3'd0,
    REG_ROT_ROW1 = 3'd1,
    REG_ROT_ROW2 = 3'd2,
    REG_CAM_X    = 3'd3,
    REG_CAM_Y    = 3'd4,
    REG_CAM_Z    = 3'd5,
    REG_FOCAL    = 3'd6
  } reg_idx_t;

endpackage

@@ sv/perspective_vertex_projection_unit.sv @@
// ----------------------------------------------------------------------------
// perspective_vertex_projection_unit
// Pinhole projection of Q4.12 vertices to saturated integer screen pixels.
// ----------------------------------------------------------------------------
//  channel  signals                                   direction
//  in       in_valid in_ready vertex_x/y/z            beat into block
//  out      out_valid out_ready proj_x/y behind_camera beat out of block
//  cfg      cfg_valid cfg_ready cfg_index cfg_data    register write
//
//  One vertex per cycle unless the output stalls; 6 arithmetic stages, 16 restoring
//  divide stages and one output register. Divide stages set the depth.
//  rst clears valid bits and sets the configuration registers to their reset values.
//  A stalled output holds every stage; nothing is dropped or repeated.
module perspective_vertex_projection_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [pvp_pkg::COORD_W-1:0] vertex_x,
  input  logic signed [pvp_pkg::COORD_W-1:0] vertex_y,
  input  logic signed [pvp_pkg::COORD_W-1:0] vertex_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [pvp_pkg::COORD_W-1:0] proj_x,
  output logic signed [pvp_pkg::COORD_W-1:0] proj_y,
  output logic                           behind_camera,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pvp_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [pvp_pkg::ROW_W-1:0]      cfg_data
);
  import pvp_pkg::*;

  logic [ROW_W-1:0]   rot [3];
  logic [COORD_W-1:0] cam [3];
  logic [FOCAL_W-1:0] focal;

  logic en;

  logic                     v1, v2, v3, v4, v5;
  logic signed [DIFF_W-1:0] s1_d [3];
  logic signed [PROD_W-1:0] s2_p [3][3];
  logic signed [DOT_W-1:0]  s3_t [3];
  logic signed [NUM_W-1:0]  s4_f [2];
  logic signed [NUM_W-1:0]  s4_h [2];
  logic signed [DOT_W-1:0]  s4_den;
  logic                     s4_bh;
  logic signed [NUM_W-1:0]  s5_n [2];
  logic signed [DOT_W-1:0]  s5_den;
  logic                     s5_bh;

  logic                 dr_vld [17];
  logic                 dr_bh  [17];
  logic [DOT_W-1:0]     dr_den [17];
  logic [NUM_W-1:0]     dr_rem [17][2];
  logic [QUO_W-1:0]     dr_q   [17][2];
  logic                 dr_neg [17][2];
  logic                 dr_ovf [17][2];

  logic [COORD_W-1:0] res [2];

  assign cfg_ready = 1'b1;
  assign en        = out_ready | ~out_valid;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0] <= ROT0_RST;
      rot[1] <= ROT1_RST;
      rot[2] <= ROT2_RST;
      cam[0] <= '0;
      cam[1] <= '0;
      cam[2] <= CAMZ_RST;
      focal  <= FOCAL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROT_ROW0: rot[0] <= cfg_data;
        REG_ROT_ROW1: rot[1] <= cfg_data;
        REG_ROT_ROW2: rot[2] <= cfg_data;
        REG_CAM_X:    cam[0] <= cfg_data[COORD_W-1:0];
        REG_CAM_Y:    cam[1] <= cfg_data[COORD_W-1:0];
        REG_CAM_Z:    cam[2] <= cfg_data[COORD_W-1:0];
        REG_FOCAL:    focal  <= cfg_data[FOCAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      dr_vld[0] <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      dr_vld[0] <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d[0] <= DIFF_W'(vertex_x) - DIFF_W'($signed(cam[0]));
      s1_d[1] <= DIFF_W'(vertex_y) - DIFF_W'($signed(cam[1]));
      s1_d[2] <= DIFF_W'(vertex_z) - DIFF_W'($signed(cam[2]));
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s2_p[i][j] <= s1_d[j] * $signed(rot[i][16*j +: 16]);
        end
        s3_t[i] <= DOT_W'(s2_p[i][0]) + DOT_W'(s2_p[i][1]) + DOT_W'(s2_p[i][2]);
      end
      s4_f[0] <= $signed({1'b0, focal}) * s3_t[0];
      s4_f[1] <= $signed({1'b0, focal}) * s3_t[1];
      s4_h[0] <= HALF_W * s3_t[2];
      s4_h[1] <= HALF_H * s3_t[2];
      s4_den  <= s3_t[2];
      s4_bh   <= (s3_t[2] <= 0);
      s5_n[0] <= s4_f[0] + s4_h[0];
      s5_n[1] <= s4_f[1] + s4_h[1];
      s5_den  <= s4_den;
      s5_bh   <= s4_bh;
      dr_den[0] <= s5_den;
      dr_bh[0]  <= s5_bh;
      for (int l = 0; l < 2; l++) begin
        dr_rem[0][l] <= s5_n[l][NUM_W-1] ? NUM_W'(-s5_n[l]) : s5_n[l];
        dr_neg[0][l] <= s5_n[l][NUM_W-1];
        dr_q[0][l]   <= '0;
        dr_ovf[0][l] <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [TRIAL_W-1:0] trial;
    logic [TRIAL_W-1:0] lim;
    logic [TRIAL_W-1:0] rem_ext [2];
    logic               ge      [2];

    assign trial = TRIAL_W'(dr_den[k]) << (QUO_W - 1 - k);
    assign lim   = TRIAL_W'(dr_den[k]) << QUO_W;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        rem_ext[l] = TRIAL_W'(dr_rem[k][l]);
        ge[l]      = rem_ext[l] >= trial;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dr_vld[k+1] <= 1'b0;
      end else if (en) begin
        dr_vld[k+1] <= dr_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dr_den[k+1] <= dr_den[k];
        dr_bh[k+1]  <= dr_bh[k];
        for (int l = 0; l < 2; l++) begin
          dr_rem[k+1][l] <= ge[l] ? NUM_W'(rem_ext[l] - trial) : dr_rem[k][l];
          dr_q[k+1][l]   <= dr_q[k][l] | (QUO_W'(ge[l]) << (QUO_W - 1 - k));
          dr_neg[k+1][l] <= dr_neg[k][l];
          dr_ovf[k+1][l] <= (k == 0) ? (rem_ext[l] >= lim) : dr_ovf[k][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (dr_bh[QUO_W]) begin
        res[l] = '0;
      end else if (!dr_neg[QUO_W][l]) begin
        res[l] = (dr_ovf[QUO_W][l] || dr_q[QUO_W][l][QUO_W-1]) ? SAT_POS : dr_q[QUO_W][l];
      end else begin
        res[l] = (dr_ovf[QUO_W][l] || dr_q[QUO_W][l] > SAT_NEG) ? SAT_NEG
                                                                : -dr_q[QUO_W][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dr_vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      proj_x        <= res[0];
      proj_y        <= res[1];
      behind_camera <= dr_bh[QUO_W];
    end
  end

  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && behind_camera |-> proj_x == 0 && proj_y == 0)
    else $error("behind_camera beat carries nonzero coordinates");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted beat missing from first stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready && dr_vld[0] |=> dr_vld[0] && $stable(dr_rem[0][0]))
    else $error("stalled stage changed");

endmodule

@@ sim/perspective_vertex_projection_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// perspective_vertex_projection_unit_test
// Streams world-space vertices through the projection unit under several
// camera, rotation and focal settings and varied handshake pressure, and
// compares every output beat with a fixed-point pinhole projection.
// ----------------------------------------------------------------------------
module perspective_vertex_projection_unit_test;
  import pvp_pkg::*;

  localparam logic [CIDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      behind;
  } pixel_t;

  class projection_scoreboard;
    logic [ROW_W-1:0]          rot[3];
    logic signed [COORD_W-1:0] cam[3];
    logic [FOCAL_W-1:0]        focal;
    pixel_t                    pixels_due[$];
    int                        errors;

    function new();
      rot[0] = ROT0_RST;
      rot[1] = ROT1_RST;
      rot[2] = ROT2_RST;
      cam[0] = '0;
      cam[1] = '0;
      cam[2] = CAMZ_RST;
      focal  = FOCAL_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [ROW_W-1:0] data);
      case (idx)
        REG_ROT_ROW0: rot[0] = data;
        REG_ROT_ROW1: rot[1] = data;
        REG_ROT_ROW2: rot[2] = data;
        REG_CAM_X:    cam[0] = data[COORD_W-1:0];
        REG_CAM_Y:    cam[1] = data[COORD_W-1:0];
        REG_CAM_Z:    cam[2] = data[COORD_W-1:0];
        REG_FOCAL:    focal  = data[FOCAL_W-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [COORD_W-1:0] screen_coord(longint num, longint den, longint half);
      longint q;
      q = (longint'(focal) * num + half * den) / den;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[COORD_W-1:0];
    endfunction

    function void note_vertex(logic signed [COORD_W-1:0] vx, vy, vz);
      longint d[3];
      longint t[3];
      pixel_t p;
      d[0] = longint'(vx) - longint'(cam[0]);
      d[1] = longint'(vy) - longint'(cam[1]);
      d[2] = longint'(vz) - longint'(cam[2]);
      for (int i = 0; i < 3; i++) begin
        t[i] = 0;
        for (int j = 0; j < 3; j++)
          t[i] += longint'($signed(rot[i][16*j +: 16])) * d[j];
      end
      if (t[2] <= 0) begin
        p = '{px: '0, py: '0, behind: 1'b1};
      end else begin
        p.px = screen_coord(t[0], t[2], longint'(HALF_W));
        p.py = screen_coord(t[1], t[2], longint'(HALF_H));
        p.behind = 1'b0;
      end
      pixels_due.push_back(p);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp_p;
      if (pixels_due.size() == 0) begin
        report_mismatch("output beat with nothing expected", 0, 0);
        return;
      end
      exp_p = pixels_due.pop_front();
      if (got.px !== exp_p.px) report_mismatch("proj_x", got.px, exp_p.px);
      if (got.py !== exp_p.py) report_mismatch("proj_y", got.py, exp_p.py);
      if (got.behind !== exp_p.behind)
        report_mismatch("behind_camera", got.behind, exp_p.behind);
    endfunction

    function void report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] vertex_x = '0, vertex_y = '0, vertex_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] proj_x, proj_y;
  logic behind_camera;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0] cfg_data = '0;

  projection_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  perspective_vertex_projection_unit u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_pixel('{px: proj_x, py: proj_y, behind: behind_camera});
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_vertex(logic signed [COORD_W-1:0] x, y, z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    vertex_x <= x;
    vertex_y <= y;
    vertex_z <= z;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    sb.note_vertex(x, y, z);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [ROW_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [ROW_W-1:0] rand_wide();
    return ROW_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ROW_W-1:0] pad16(logic [COORD_W-1:0] v);
    logic [ROW_W-1:0] r;
    r = rand_wide();
    r[COORD_W-1:0] = v;
    return r;
  endfunction

  task automatic random_vertices(int count);
    logic signed [COORD_W-1:0] x, y, z;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(2) == 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
      end else begin
        x = sb.cam[0] + $signed(16'($urandom_range(8191))) - 16'sd4096;
        y = sb.cam[1] + $signed(16'($urandom_range(8191))) - 16'sd4096;
        z = sb.cam[2] + $signed(16'($urandom_range(16383))) - 16'sd2048;
      end
      send_vertex(x, y, z);
    end
  endtask

  task automatic set_rotation(logic [ROW_W-1:0] r0, r1, r2);
    cfg_write(REG_ROT_ROW0, r0);
    cfg_write(REG_ROT_ROW1, r1);
    cfg_write(REG_ROT_ROW2, r2);
  endtask

  task automatic set_camera(logic [COORD_W-1:0] cx, cy, cz, logic [FOCAL_W-1:0] f);
    cfg_write(REG_CAM_X, pad16(cx));
    cfg_write(REG_CAM_Y, pad16(cy));
    cfg_write(REG_CAM_Z, pad16(cz));
    cfg_write(REG_FOCAL, {(ROW_W-FOCAL_W)'(rand_wide()), f});
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, depth zero, just in front, saturation both ways
    send_vertex(16'sh0000, 16'sh0000, 16'sh0000);
    send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
    send_vertex(16'sh7FFF, 16'sh8000, 16'shCFFC);
    send_vertex(16'sh1234, 16'sh4321, 16'shCFFD);
    send_vertex(16'sh7FFF, 16'sh0000, 16'shCFFD);
    send_vertex(16'sh8000, 16'sh7FFF, 16'shCFFD);
    send_vertex(16'sh8000, 16'sh8000, 16'sh7FFF);
    send_vertex(16'sh0400, 16'shFC00, 16'shCFFB);
    send_vertex(16'sh0001, 16'shFFFF, 16'sh0000);
    drain();
    cfg_write(REG_UNUSED, rand_wide());
    set_camera(16'h8000, 16'h7FFF, 16'h8000, 12'd4095);
    send_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_vertex(16'sh8000, 16'sh7FFF, 16'sh8001);
    send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh8000);
    drain();
    set_rotation(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000);
    set_camera(16'h7FFF, 16'h7FFF, 16'h7FFF, 12'd0);
    send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
    send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          set_rotation(ROT0_RST, ROT1_RST, ROT2_RST);
          set_camera(16'h0000, 16'h0000, CAMZ_RST, FOCAL_RST);
        end
        1: set_rotation(rand_wide(), rand_wide(), rand_wide());
        2: begin
          set_rotation(48'h0000_0000_7FFF, 48'h0000_7FFF_0000, 48'h7FFF_0000_0000);
          set_camera(16'($urandom), 16'($urandom), 16'h8000, 12'd4095);
        end
        3: set_camera(16'($urandom), 16'($urandom), 16'($urandom), 12'd1);
        4: set_rotation(48'h0, 48'h0, 48'h0);
        5: begin
          set_rotation(48'h0000_2D41_2D41, 48'h2D41_D2BF_0000, 48'hC000_0000_4000);
          set_camera(16'($urandom), 16'($urandom), 16'($urandom), 12'($urandom));
        end
        6: set_rotation(48'hFFFF_0001_C000, 48'h0000_C000_0000, 48'h0000_0000_C000);
        default: begin
          set_rotation(ROT0_RST, ROT1_RST, ROT2_RST);
          set_camera(16'($urandom), 16'($urandom), 16'($urandom), 12'($urandom));
        end
      endcase
      send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 17 : 74) : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 17 : 74) : 0;
      if (ph == 2) begin
        send_idle_pct = 0;
        hold_req = 1;
      end
      random_vertices(100);
      if (ph == 5) begin
        in_valid <= 1'b0;
        while (sb.pixels_due.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      random_vertices(105);
      drain();
    end

    if (sb.pixels_due.size() != 0)
      sb.report_mismatch("results never produced", 0, sb.pixels_due.size());
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
